// ===== hw/rtl/tkis_pkg.sv =====
// ----------------------------------------------------------------------------
// tkis_pkg: shared definitions for the top-k index selector
// Field widths, parameter defaults, and the command and status bundles that
// run between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tkis_pkg;

    // Parameter defaults
    localparam int MAX_KEEP_DEF      = 8;
    localparam int POSITION_BITS_DEF = 16;

    // Fixed field widths
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 4;
    localparam int RANK_OUT_W = 3;
    localparam int POS_OUT_W  = 16;

    // Keep count after reset
    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd5;

    // Controller to datapath
    typedef struct packed {
        logic insert;   // an input transaction completes this cycle
        logic advance;  // a result transaction completes this cycle
        logic finish;   // the final result of the report completes
    } tkis_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_rank; // the rank on the output is the final one
    } tkis_sts_t;

endpackage : tkis_pkg

`default_nettype wire

// ===== hw/rtl/tkis_ctrl.sv =====
// ----------------------------------------------------------------------------
// tkis_ctrl: run and report controller
// Accepts samples while collecting; after the end-of-run sample it walks the
// report, one result transaction per rank, then returns to collecting.
// ----------------------------------------------------------------------------
`default_nettype none

module tkis_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire logic               end_of_run,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output tkis_pkg::tkis_cmd_t     cmd,
    input  wire tkis_pkg::tkis_sts_t sts
);

    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_REPORT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Handshake follows state directly
    assign sample_stall = (state_reg == ST_REPORT);
    assign result_valid = (state_reg == ST_REPORT);

    // Commands for the datapath
    always_comb
    begin
        cmd.insert  = sample_valid && !sample_stall;
        cmd.advance = result_valid && !result_stall;
        cmd.finish  = result_valid && !result_stall && sts.last_rank;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (cmd.insert && end_of_run)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (cmd.finish)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule : tkis_ctrl

`default_nettype wire

// ===== hw/rtl/tkis_dp.sv =====
// ----------------------------------------------------------------------------
// tkis_dp: insertion cells, position counter and report mux
// A row of compare-and-shift cells keeps the list sorted in descending order;
// a new sample is placed in its cell as it is accepted. The report reads one rank per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module tkis_dp
#(
    parameter int MAX_KEEP      = tkis_pkg::MAX_KEEP_DEF,
    parameter int POSITION_BITS = tkis_pkg::POSITION_BITS_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tkis_pkg::tkis_cmd_t                 cmd,
    output tkis_pkg::tkis_sts_t                      sts,
    input  wire logic                                cfg_write_en,
    input  wire logic [tkis_pkg::COUNT_W-1:0]        cfg_write_data,
    input  wire logic signed [tkis_pkg::VALUE_W-1:0] sample_value,
    output logic [tkis_pkg::RANK_OUT_W-1:0]          rank,
    output logic [tkis_pkg::POS_OUT_W-1:0]           position,
    output logic signed [tkis_pkg::VALUE_W-1:0]      top_value,
    output logic                                     filled,
    output logic                                     overflow,
    output logic                                     final_rank
);

    localparam int RANK_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    // Register and run state
    logic [tkis_pkg::COUNT_W-1:0]        count_reg;
    logic signed [tkis_pkg::VALUE_W-1:0] val_reg   [MAX_KEEP];
    logic signed [tkis_pkg::VALUE_W-1:0] val_next  [MAX_KEEP];
    logic [POSITION_BITS-1:0]            pos_reg   [MAX_KEEP];
    logic [POSITION_BITS-1:0]            pos_next  [MAX_KEEP];
    logic [MAX_KEEP-1:0]                 valid_reg;
    logic [MAX_KEEP-1:0]                 valid_next;
    logic [POSITION_BITS-1:0]            elem_cnt_reg;
    logic                                ovf_reg;
    logic [RANK_W-1:0]                   rank_cnt_reg;

    logic                                at_limit;
    logic                                do_insert;
    logic [MAX_KEEP-1:0]                 goes_here;

    // Keep count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= tkis_pkg::COUNT_RESET;
        end
        else if (cfg_write_en)
        begin
            count_reg <= cfg_write_data;
        end
    end

    // Drop samples once the position counter is saturated
    assign at_limit  = (elem_cnt_reg == {POSITION_BITS{1'b1}});
    assign do_insert = cmd.insert && !at_limit;

    // Compare-and-shift cells
    for (genvar j = 0; j < MAX_KEEP; j++)
    begin : g_cell
        assign goes_here[j] = !valid_reg[j] || (sample_value > val_reg[j]);

        if (j == 0)
        begin : g_head
            always_comb
            begin
                val_next[j]   = val_reg[j];
                pos_next[j]   = pos_reg[j];
                valid_next[j] = valid_reg[j];
                if (do_insert && goes_here[j])
                begin
                    val_next[j]   = sample_value;
                    pos_next[j]   = elem_cnt_reg;
                    valid_next[j] = 1'b1;
                end
            end
        end
        else
        begin : g_body
            always_comb
            begin
                val_next[j]   = val_reg[j];
                pos_next[j]   = pos_reg[j];
                valid_next[j] = valid_reg[j];
                if (do_insert && goes_here[j-1])
                begin
                    // shift down from the cell above
                    val_next[j]   = val_reg[j-1];
                    pos_next[j]   = pos_reg[j-1];
                    valid_next[j] = valid_reg[j-1];
                end
                else if (do_insert && goes_here[j])
                begin
                    val_next[j]   = sample_value;
                    pos_next[j]   = elem_cnt_reg;
                    valid_next[j] = 1'b1;
                end
            end
        end
    end

    // Cell payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            val_reg[i] <= val_next[i];
            pos_reg[i] <= pos_next[i];
        end
    end

    // Run control state: valid bits, counter, overflow, report rank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            elem_cnt_reg <= '0;
            ovf_reg      <= 1'b0;
            rank_cnt_reg <= '0;
        end
        else if (cmd.finish)
        begin
            valid_reg    <= '0;
            elem_cnt_reg <= '0;
            ovf_reg      <= 1'b0;
            rank_cnt_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.insert)
            begin
                if (at_limit)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    elem_cnt_reg <= elem_cnt_reg + 1'b1;
                end
            end
            if (cmd.advance)
            begin
                rank_cnt_reg <= rank_cnt_reg + 1'b1;
            end
        end
    end

    // Final rank index from the clamped count
    logic [31:0]       count_wide;
    logic [31:0]       count_less;
    logic [RANK_W-1:0] last_idx;

    assign count_wide = {{(32 - tkis_pkg::COUNT_W){1'b0}}, count_reg};
    assign count_less = count_wide - 32'd1;

    always_comb
    begin
        if (count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (count_wide > 32'(MAX_KEEP))
        begin
            last_idx = RANK_W'(MAX_KEEP - 1);
        end
        else
        begin
            last_idx = count_less[RANK_W-1:0];
        end
    end

    assign sts.last_rank = (rank_cnt_reg == last_idx);

    // Report mux; empty ranks read as zero
    logic [RANK_W+tkis_pkg::RANK_OUT_W-1:0]       rank_wide;
    logic [POSITION_BITS+tkis_pkg::POS_OUT_W-1:0] pos_wide;

    assign rank_wide = {{tkis_pkg::RANK_OUT_W{1'b0}}, rank_cnt_reg};
    assign pos_wide  = {{tkis_pkg::POS_OUT_W{1'b0}}, pos_reg[rank_cnt_reg]};

    assign rank       = rank_wide[tkis_pkg::RANK_OUT_W-1:0];
    assign filled     = valid_reg[rank_cnt_reg];
    assign position   = filled ? pos_wide[tkis_pkg::POS_OUT_W-1:0] : '0;
    assign top_value  = filled ? val_reg[rank_cnt_reg] : '0;
    assign overflow   = ovf_reg;
    assign final_rank = sts.last_rank;

endmodule : tkis_dp

`default_nettype wire

// ===== hw/rtl/top_k_index_selector.sv =====
// ----------------------------------------------------------------------------
// top_k_index_selector: streaming top-k selection with positions
// Latency: a sample is inserted in the cycle it is accepted; after the
//   end-of-run sample the first result is offered on the next cycle.
// Throughput: one sample per cycle while collecting, set by the insertion cells;
//   a report then offers one result per rank (count clamped to 1..MAX_KEEP)
//   and can be held by result stalls; samples are stalled throughout a report.
// Reset: clears the list, position counter and overflow flag; keep count 5.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_index_selector
#(
    parameter int MAX_KEEP      = tkis_pkg::MAX_KEEP_DEF,
    parameter int POSITION_BITS = tkis_pkg::POSITION_BITS_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_en,
    input  wire logic [tkis_pkg::COUNT_W-1:0]        cfg_write_data,
    input  wire logic                                sample_valid,
    output logic                                     sample_stall,
    input  wire logic signed [tkis_pkg::VALUE_W-1:0] sample_value,
    input  wire logic                                end_of_run,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic [tkis_pkg::RANK_OUT_W-1:0]          rank,
    output logic [tkis_pkg::POS_OUT_W-1:0]           position,
    output logic signed [tkis_pkg::VALUE_W-1:0]      top_value,
    output logic                                     filled,
    output logic                                     overflow,
    output logic                                     final_rank
);

    tkis_pkg::tkis_cmd_t cmd;
    tkis_pkg::tkis_sts_t sts;

    // Controller
    tkis_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .end_of_run   (end_of_run),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

    // Datapath
    tkis_dp
    #(
        .MAX_KEEP      (MAX_KEEP),
        .POSITION_BITS (POSITION_BITS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .sample_value   (sample_value),
        .rank           (rank),
        .position       (position),
        .top_value      (top_value),
        .filled         (filled),
        .overflow       (overflow),
        .final_rank     (final_rank)
    );

endmodule : top_k_index_selector

`default_nettype wire

// ===== hw/rtl/tkis_chk.sv =====
// ----------------------------------------------------------------------------
// tkis_chk: port-level checks for the top-k index selector
// Watches the report sequence and the coupling of the two channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tkis_chk
(
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                sample_valid,
    input wire logic                                sample_stall,
    input wire logic                                end_of_run,
    input wire logic                                result_valid,
    input wire logic                                result_stall,
    input wire logic [tkis_pkg::RANK_OUT_W-1:0]     rank,
    input wire logic [tkis_pkg::POS_OUT_W-1:0]      position,
    input wire logic [tkis_pkg::VALUE_W-1:0]        top_value,
    input wire logic                                filled,
    input wire logic                                final_rank
);

    // Samples stall exactly while a report is offered
    a_stall_matches_report: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall == result_valid)
        else $error("sample stall does not track report");

    // End of run starts a report at rank zero
    a_report_starts: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall && end_of_run |=> result_valid && rank == '0)
        else $error("report did not start at rank zero");

    // Ranks step by one within a report
    a_rank_steps: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !final_rank
        |=> result_valid && rank == $past(rank) + 3'd1)
        else $error("rank did not advance by one");

    // Report ends after the final rank
    a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && final_rank |=> !result_valid)
        else $error("report continued past final rank");

    // Empty ranks carry zero payload
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !filled |-> position == '0 && top_value == '0)
        else $error("empty rank carries nonzero payload");

endmodule : tkis_chk

bind top_k_index_selector tkis_chk u_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .end_of_run   (end_of_run),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .rank         (rank),
    .position     (position),
    .top_value    (top_value),
    .filled       (filled),
    .final_rank   (final_rank)
);

`default_nettype wire
